// ----- hw/rtl/cele_pkg.sv -----
// ----------------------------------------------------------------------------
// cele_pkg: shared definitions of the complex entry list engine
// Operation and status codes, cell modes, controller states and field widths.
// ----------------------------------------------------------------------------
package cele_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int PART_WIDTH_DEF = 32;

    localparam int OP_W     = 3;
    localparam int FIELD_W  = 32;
    localparam int AMT_W    = 8;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_POP    = 3'd1,
        OP_DELETE = 3'd2,
        OP_ROT_L  = 3'd3,
        OP_ROT_R  = 3'd4,
        OP_SEARCH = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // What one cell of the row does at the coming clock edge.
    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_LOAD   = 2'd1,
        CM_SHIFT  = 2'd2,
        CM_SEARCH = 2'd3
    } cell_mode_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_MOD  = 3'd1,
        S_ROT  = 3'd2,
        S_SRCH = 3'd3,
        S_DONE = 3'd4
    } state_t;

endpackage

// ----- hw/rtl/cele_if.sv -----
// ----------------------------------------------------------------------------
// cele_if: command and response channels of the complex entry list engine
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cele_cmd_if;
    import cele_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [FIELD_W-1:0] entry_real;
    logic signed [FIELD_W-1:0] entry_imag;
    logic [AMT_W-1:0]          amount;

    modport source (output valid, op, entry_real, entry_imag, amount, input ready);
    modport sink   (input valid, op, entry_real, entry_imag, amount, output ready);
endinterface

interface cele_rsp_if;
    import cele_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [FILL_W-1:0]   fill;

    modport source (output valid, status, found, fill, input ready);
    modport sink   (input valid, status, found, fill, output ready);
endinterface

// ----- hw/rtl/cele_cell.sv -----
// ----------------------------------------------------------------------------
// cele_cell: one storage cell of the entry row
// Holds one complex entry; loads new data, takes its neighbor's entry, or
// compares its entry with the search key.
// ----------------------------------------------------------------------------
module cele_cell #(
    parameter int PART_WIDTH = cele_pkg::PART_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cele_pkg::cell_mode_t   mode,
    input  logic [PART_WIDTH-1:0]  load_real,
    input  logic [PART_WIDTH-1:0]  load_imag,
    input  logic [PART_WIDTH-1:0]  nbr_real,
    input  logic [PART_WIDTH-1:0]  nbr_imag,
    output logic [PART_WIDTH-1:0]  cur_real,
    output logic [PART_WIDTH-1:0]  cur_imag,
    output logic                   hit
);
    import cele_pkg::*;

    logic [PART_WIDTH-1:0] real_reg;
    logic [PART_WIDTH-1:0] real_next;
    logic [PART_WIDTH-1:0] imag_reg;
    logic [PART_WIDTH-1:0] imag_next;
    logic                  hit_reg;
    logic                  hit_next;

    always_comb
    begin
        real_next = real_reg;
        imag_next = imag_reg;
        hit_next  = 1'b0;
        case (mode)
            CM_LOAD:
            begin
                real_next = load_real;
                imag_next = load_imag;
            end
            CM_SHIFT:
            begin
                real_next = nbr_real;
                imag_next = nbr_imag;
            end
            CM_SEARCH:
            begin
                hit_next = (real_reg == load_real) && (imag_reg == load_imag);
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        real_reg <= real_next;
        imag_reg <= imag_next;
    end

    assign cur_real = real_reg;
    assign cur_imag = imag_reg;
    assign hit      = hit_reg;

endmodule

// ----- hw/rtl/cele_mod.sv -----
// ----------------------------------------------------------------------------
// cele_mod: bit-serial remainder unit
// Reduces the rotation distance modulo the entry count, one bit per cycle.
// ----------------------------------------------------------------------------
module cele_mod #(
    parameter int CW = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cele_pkg::AMT_W-1:0]    dividend,
    input  logic [CW-1:0]                 divisor,
    output logic                          done,
    output logic [CW-1:0]                 rem
);
    import cele_pkg::*;

    localparam int STEP_W = $clog2(AMT_W);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              done_reg;
    logic              done_next;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     rem_next;
    logic [AMT_W-1:0]  dvd_reg;
    logic [AMT_W-1:0]  dvd_next;
    logic [CW-1:0]     div_reg;
    logic [CW-1:0]     div_next;
    logic [CW:0]       trial;
    logic              fits;

    // The partial remainder stays below the divisor, so the trial value is
    // below twice the divisor and one subtraction restores it.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[AMT_W-1]};
        fits  = trial >= {1'b0, div_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(AMT_W - 1);
            rem_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? CW'(trial - {1'b0, div_reg}) : CW'(trial);
            dvd_next = {dvd_reg[AMT_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- hw/rtl/complex_entry_list_engine.sv -----
// Path from accept to the output register: append, remove last, delete and every
// error case go straight to S_DONE; search passes through S_SRCH; a rotation waits
// in S_MOD for the remainder unit, then shifts in S_ROT for the reduced left
// distance (below the entry count). One item is worked on at a time; the next is
// accepted once the previous response enters the output register.
// Reset (rst_n, asynchronous, active low) empties the list and the output.
// ----------------------------------------------------------------------------
// complex_entry_list_engine: ordered list of complex integer entries
// A row of DEPTH cells holds the list in order from cell 0. Append writes the
// cell at the tail, delete shifts the cells past the position down by one in
// a single step, and a rotation shifts the occupied cells left by one place
// per cycle, the head wrapping around to the tail. Search compares all occupied cells
// at once and ORs the registered hit flags.
// ----------------------------------------------------------------------------
module complex_entry_list_engine #(
    parameter int DEPTH      = cele_pkg::DEPTH_DEF,
    parameter int PART_WIDTH = cele_pkg::PART_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cele_cmd_if.sink    cmd,
    cele_rsp_if.source  rsp
);
    import cele_pkg::*;

    // Entry count width, and a width that holds both the count and a position.
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > AMT_W) ? CW : AMT_W;

    state_t                state_reg;
    state_t                state_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    status_t               status_reg;
    status_t               status_next;
    logic                  found_reg;
    logic                  found_next;
    logic                  right_reg;
    logic                  right_next;
    logic [CW-1:0]         rot_cnt_reg;
    logic [CW-1:0]         rot_cnt_next;

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic [STATUS_W-1:0]   rsp_status_reg;
    logic                  rsp_found_reg;
    logic [FILL_W-1:0]     rsp_fill_reg;

    logic                  accept;
    op_t                   op;
    logic                  is_empty;
    logic                  is_full;
    logic                  pos_ok;
    logic                  rsp_load;
    logic                  app_load;
    logic                  del_step;
    logic                  rot_step;
    logic                  srch;
    logic                  mod_start;
    logic                  mod_done;
    logic [CW-1:0]         mod_rem;
    logic [CW-1:0]         rot_dist;

    logic [PART_WIDTH-1:0] key_real;
    logic [PART_WIDTH-1:0] key_imag;
    logic [PART_WIDTH-1:0] cell_real [DEPTH];
    logic [PART_WIDTH-1:0] cell_imag [DEPTH];
    logic [PART_WIDTH-1:0] nbr_real  [DEPTH];
    logic [PART_WIDTH-1:0] nbr_imag  [DEPTH];
    cell_mode_t            cell_mode [DEPTH];
    logic [DEPTH-1:0]      hits;

    // Commands are taken only while no item is in flight.
    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign op        = op_t'(cmd.op);

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign pos_ok   = (cmd.amount != '0) && (CMP_W'(cmd.amount) <= CMP_W'(count_reg));

    // The 32-bit signed parts are sign-extended or cut to the stored width.
    assign key_real = PART_WIDTH'(cmd.entry_real);
    assign key_imag = PART_WIDTH'(cmd.entry_imag);

    // A right rotation by r equals a left rotation by count - r.
    assign rot_dist = (right_reg && (mod_rem != '0)) ? (count_reg - mod_rem) : mod_rem;

    // The output register frees up when it is empty or being drained.
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    cele_mod #(
        .CW (CW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (cmd.amount),
        .divisor  (count_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_ROT_L, OP_ROT_R:
                        begin
                            state_next = is_empty ? S_DONE : S_MOD;
                        end
                        OP_SEARCH:
                        begin
                            state_next = S_SRCH;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = (rot_dist == '0) ? S_DONE : S_ROT;
                end
            end
            S_ROT:
            begin
                if (rot_cnt_reg == CW'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_SRCH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controls and result bookkeeping.
    always_comb
    begin
        count_next   = count_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        right_next   = right_reg;
        rot_cnt_next = rot_cnt_reg;
        app_load     = 1'b0;
        del_step     = 1'b0;
        rot_step     = 1'b0;
        srch         = 1'b0;
        mod_start    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    right_next  = (op == OP_ROT_R);
                    case (op)
                        OP_APPEND:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                app_load   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                del_step   = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_ROT_L, OP_ROT_R:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mod_start = 1'b1;
                            end
                        end
                        OP_SEARCH:
                        begin
                            srch = 1'b1;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    rot_cnt_next = rot_dist;
                end
            end
            S_ROT:
            begin
                rot_step     = 1'b1;
                rot_cnt_next = rot_cnt_reg - 1'b1;
            end
            S_SRCH:
            begin
                found_next = |hits;
            end
            default:
            begin
                rot_cnt_next = rot_cnt_reg;
            end
        endcase
    end

    // The cell row. Each cell takes its upper neighbor on a shift; the last
    // occupied cell takes the head instead, which closes the rotation ring.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_tail
            assign nbr_real[i] = cell_real[0];
            assign nbr_imag[i] = cell_imag[0];
        end
        else
        begin : g_body
            assign nbr_real[i] = (count_reg == CW'(i + 1)) ? cell_real[0] : cell_real[i + 1];
            assign nbr_imag[i] = (count_reg == CW'(i + 1)) ? cell_imag[0] : cell_imag[i + 1];
        end

        always_comb
        begin
            cell_mode[i] = CM_HOLD;
            if (app_load && (count_reg == CW'(i)))
            begin
                cell_mode[i] = CM_LOAD;
            end
            else if (del_step && (CMP_W'(i + 1) >= CMP_W'(cmd.amount))
                     && (CW'(i + 1) < count_reg))
            begin
                cell_mode[i] = CM_SHIFT;
            end
            else if (rot_step && (CW'(i) < count_reg))
            begin
                cell_mode[i] = CM_SHIFT;
            end
            else if (srch && (CW'(i) < count_reg))
            begin
                cell_mode[i] = CM_SEARCH;
            end
        end

        cele_cell #(
            .PART_WIDTH (PART_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .mode      (cell_mode[i]),
            .load_real (key_real),
            .load_imag (key_imag),
            .nbr_real  (nbr_real[i]),
            .nbr_imag  (nbr_imag[i]),
            .cur_real  (cell_real[i]),
            .cur_imag  (cell_imag[i]),
            .hit       (hits[i])
        );
    end

    // Output register.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            status_reg    <= ST_OK;
            found_reg     <= 1'b0;
            right_reg     <= 1'b0;
            rot_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
            right_reg     <= right_next;
            rot_cnt_reg   <= rot_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_status_reg <= status_reg;
            rsp_found_reg  <= found_reg;
            rsp_fill_reg   <= FILL_W'(count_reg);
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.found  = rsp_found_reg;
    assign rsp.fill   = rsp_fill_reg;

    // The list never holds more entries than there are cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds the cell row");

    // An append to a list with room grows it by exactly one entry.
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.op == OP_APPEND) && !is_full |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append did not grow the list by one");

    // A rotation in progress always has shifts left to do.
    a_rot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROT |-> rot_cnt_reg != '0)
        else $error("rotation running with no distance left");

    // Rotation shifts never change the number of entries.
    a_rot_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROT |=> $stable(count_reg))
        else $error("entry count changed during a rotation");

    // A remainder is reported only while the controller waits for it.
    a_mod_state: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == S_MOD)
        else $error("remainder unit finished outside the wait state");

endmodule

// ----- verif/cele_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cele_list_checker: scoreboard for the complex entry list engine
// Watches both channels and keeps its own copy of the list. Each accepted
// command item is applied to that copy, and the outcome is queued. Each
// accepted response is compared with the oldest queued outcome.
// ----------------------------------------------------------------------------
module cele_list_checker (
    input  logic clk,
    input  logic rst_n,
    cele_cmd_if  cmd,
    cele_rsp_if  rsp,
    output int   fails,
    output int   pending
);
    import cele_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;

    typedef struct packed {
        logic [FIELD_W-1:0] re;
        logic [FIELD_W-1:0] im;
    } cplx_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [FILL_W-1:0]   fill;
    } reply_t;

    cplx_t  model_list[$];
    reply_t replies_due[$];
    reply_t want;
    int     fail_count;
    int     due_count;

    initial
    begin
        fail_count = 0;
        due_count  = 0;
    end

    assign fails   = fail_count;
    assign pending = due_count;

    // Applies one operation to the list copy and returns the reply it earns.
    function automatic reply_t run_list_op(input logic [OP_W-1:0] op, input cplx_t val,
                                           input logic [AMT_W-1:0] amt);
        reply_t r;
        int     k;
        r.status = ST_OK;
        r.found  = 1'b0;
        case (op)
            OP_APPEND:
                if (model_list.size() >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                    model_list.push_back(val);
            OP_POP:
                if (model_list.size() == 0)
                    r.status = ST_EMPTY;
                else
                    void'(model_list.pop_back());
            OP_DELETE:
                if (model_list.size() == 0)
                    r.status = ST_EMPTY;
                else if (amt == 0 || int'(amt) > model_list.size())
                    r.status = ST_RANGE;
                else
                    model_list.delete(int'(amt) - 1);
            OP_ROT_L, OP_ROT_R:
                if (model_list.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    k = int'(amt) % model_list.size();
                    if (k != 0 && op == OP_ROT_R)
                        k = model_list.size() - k;
                    repeat (k) model_list.push_back(model_list.pop_front());
                end
            OP_SEARCH:
                foreach (model_list[i])
                    if (model_list[i] == val)
                        r.found = 1'b1;
            default:
                ;
        endcase
        r.fill = FILL_W'(model_list.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_list.delete();
            replies_due.delete();
        end
        else
        begin
            // A response accepted at this edge belongs to an earlier command.
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("response item with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, rsp.found);
                        fail_count++;
                    end
                    if (rsp.fill !== want.fill)
                    begin
                        $error("fill: expected %0d, actual %0d", want.fill, rsp.fill);
                        fail_count++;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                replies_due.push_back(run_list_op(cmd.op,
                    cplx_t'{re: cmd.entry_real, im: cmd.entry_imag}, cmd.amount));
        end
        due_count = replies_due.size();
    end

endmodule

// ----- verif/complex_entry_list_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_entry_list_engine_tb: stimulus and verdict for the list engine
// Drives command items with random gaps, takes responses with random stalls,
// and leaves all prediction and comparison to the checker beside the block.
// A short directed opening covers the error cases and the value extremes;
// the random body then swings the list between empty and full.
// ----------------------------------------------------------------------------
module complex_entry_list_engine_tb;
    import cele_pkg::*;

    // Op codes the block does not define; they must change nothing.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1650;
    // The slowest item is a rotation: the remainder step plus up to DEPTH - 1 shifts.
    localparam int SETTLE_CYCLES = LIST_DEPTH + 16;
    localparam int BLOCK_ITEMS   = 50;

    logic clk = 1'b0;
    logic rst_n;
    int   fails;
    int   pending;

    // When set, the matching side runs without any idle cycles.
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    // Recently appended values, so that searches can hit or nearly hit.
    logic [FIELD_W-1:0] seen_re[$];
    logic [FIELD_W-1:0] seen_im[$];

    cele_cmd_if cmd();
    cele_rsp_if rsp();

    complex_entry_list_engine uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    cele_list_checker list_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rsp     (rsp),
        .fails   (fails),
        .pending (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // One of the four corner values of a signed part, picked by k.
    function automatic logic [FIELD_W-1:0] corner_part(input int k);
        case (k % 4)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Random part value, leaning on the corners and on small numbers now and then.
    function automatic logic [FIELD_W-1:0] draw_part();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return corner_part($urandom_range(0, 3));
        else if (pick == 2)
            return $urandom_range(0, 15);
        else
            return $urandom;
    endfunction

    // Offers one command item after a random gap and returns at the falling
    // edge after it was accepted. Valid stays high when the next gap is zero,
    // so back-to-back items really go back to back.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] re,
                            input logic [FIELD_W-1:0] im, input logic [AMT_W-1:0] amt);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.op         <= op;
        cmd.entry_real <= re;
        cmd.entry_imag <= im;
        cmd.amount     <= amt;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        @(negedge clk);
        if (op == OP_APPEND)
        begin
            seen_re.push_back(re);
            seen_im.push_back(im);
            if (seen_re.size() > 32)
            begin
                void'(seen_re.pop_front());
                void'(seen_im.pop_front());
            end
        end
    endtask

    // Holds the command channel idle until every response has come back.
    task automatic drain_responses();
        cmd.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // One random item. The grow bias fills the list up to full, the shrink
    // bias empties it, and the mixed bias keeps it wandering in between.
    task automatic random_cmd(input int bias);
        int                 pick;
        int                 j;
        int                 append_pct;
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] re;
        logic [FIELD_W-1:0] im;
        logic [AMT_W-1:0]   amt;
        append_pct = (bias == 0) ? 55 : (bias == 1) ? 15 : 30;
        re  = draw_part();
        im  = draw_part();
        amt = AMT_W'($urandom);
        if ($urandom_range(0, 99) < append_pct)
        begin
            op = OP_APPEND;
            // Duplicates make searches match more than one entry.
            if (seen_re.size() > 0 && $urandom_range(0, 4) == 0)
            begin
                j  = $urandom_range(0, seen_re.size() - 1);
                re = seen_re[j];
                im = seen_im[j];
            end
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                op = OP_POP;
            else if (pick < 40)
                op = OP_DELETE;
            else if (pick < 57)
                op = OP_ROT_L;
            else if (pick < 74)
                op = OP_ROT_R;
            else if (pick < 97)
                op = OP_SEARCH;
            else
                op = (pick == 99) ? OP_SPARE_B : OP_SPARE_A;
        end
        case (op)
            OP_DELETE:
                if ($urandom_range(0, 3) != 0)
                    amt = AMT_W'($urandom_range(0, LIST_DEPTH + 1));
            OP_ROT_L, OP_ROT_R:
                if ($urandom_range(0, 3) != 0)
                    amt = AMT_W'($urandom_range(0, 2 * LIST_DEPTH));
            OP_SEARCH:
                // Mostly look for a value that was appended, sometimes with
                // one bit flipped in one part to make a near miss.
                if (seen_re.size() > 0 && $urandom_range(0, 3) != 0)
                begin
                    j  = $urandom_range(0, seen_re.size() - 1);
                    re = seen_re[j];
                    im = seen_im[j];
                    if ($urandom_range(0, 3) == 0)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            re = re ^ (32'd1 << $urandom_range(0, FIELD_W - 1));
                        else
                            im = im ^ (32'd1 << $urandom_range(0, FIELD_W - 1));
                    end
                end
            default:
                ;
        endcase
        send_cmd(op, re, im, amt);
    endtask

    // Response side: before each item, stall for a random number of cycles,
    // then keep ready high until a response is taken.
    initial
    begin
        int stall;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = recv_calm ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int bias;
        rst_n          <= 1'b0;
        cmd.valid      <= 1'b0;
        cmd.op         <= OP_APPEND;
        cmd.entry_real <= '0;
        cmd.entry_imag <= '0;
        cmd.amount     <= '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every operation that needs entries, tried on an empty list. A search
        // here must report not found with an ok status.
        send_cmd(OP_SEARCH, '0, '0, 8'd0);
        send_cmd(OP_POP, '0, '0, 8'd0);
        send_cmd(OP_DELETE, '1, '1, 8'd1);
        send_cmd(OP_ROT_L, '0, '0, 8'd1);
        send_cmd(OP_ROT_R, '0, '0, 8'd255);

        // Fill the list, the first half with corner values in both parts.
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (i < LIST_DEPTH / 2)
                send_cmd(OP_APPEND, corner_part(i), corner_part(i / 4 + 1), 8'd0);
            else
                send_cmd(OP_APPEND, draw_part(), draw_part(), 8'hFF);
        end
        // Appending to a full list is refused and leaves it as it was.
        send_cmd(OP_APPEND, 32'h1234_5678, 32'h9ABC_DEF0, 8'd0);

        // Delete positions: zero and past the end are out of range, then the
        // last and the first entries go.
        send_cmd(OP_DELETE, '0, '0, 8'd0);
        send_cmd(OP_DELETE, '0, '0, AMT_W'(LIST_DEPTH + 1));
        send_cmd(OP_DELETE, '0, '0, AMT_W'(LIST_DEPTH));
        send_cmd(OP_DELETE, '0, '0, 8'd1);

        // 255 reduces to a real rotation; a multiple of the count is no change.
        send_cmd(OP_ROT_L, '0, '0, 8'd255);
        send_cmd(OP_ROT_R, '0, '0, AMT_W'(LIST_DEPTH - 2));
        send_cmd(OP_SEARCH, seen_re[5], seen_im[5], 8'd0);
        send_cmd(OP_SEARCH, seen_re[5], seen_im[5] ^ 32'h0000_0001, 8'd0);
        send_cmd(OP_SPARE_A, '1, '1, 8'hFF);
        send_cmd(OP_SPARE_B, '0, '0, 8'd3);
        drain_responses();

        // Random body, in blocks that each pick a list bias and idle pattern.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % BLOCK_ITEMS == 0)
            begin
                bias      = $urandom_range(0, 2);
                send_calm = ($urandom_range(0, 3) == 0);
                recv_calm = ($urandom_range(0, 3) == 0);
                if (n % (8 * BLOCK_ITEMS) == 4 * BLOCK_ITEMS)
                    drain_responses();
            end
            random_cmd(bias);
        end

        cmd.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Several times the slowest legal run; anything longer is a hang.
    initial
    begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cele_pkg.sv
hw/rtl/cele_if.sv
hw/rtl/cele_cell.sv
hw/rtl/cele_mod.sv
hw/rtl/complex_entry_list_engine.sv
verif/cele_list_checker.sv
verif/complex_entry_list_engine_tb.sv
